[sv/lac_pkg.sv]
`timescale 1ns / 1ps
// shared types and codes for the lru associative cache core
// no dependencies

package lac_pkg;

    localparam int CNT_BITS = 32;

    typedef enum logic [1:0] {
        MODE_GET   = 2'd0,
        MODE_PUT   = 2'd1,
        MODE_INVAL = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_READ,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic look;
        logic read;
        logic commit;
    } cmd_t;

endpackage

[sv/lac_ctrl.sv]
`timescale 1ns / 1ps
// controller state machine for the lru associative cache core
// depends on lac_pkg

module lac_ctrl (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output lac_pkg::cmd_t cmd
);
    import lac_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

[sv/lac_datapath.sv]
`timescale 1ns / 1ps
// key store, recency ranks, data and key memories, counters and result registers
// depends on lac_pkg

module lac_datapath #(
    parameter int ENTRIES   = 64,
    parameter int KEY_BITS  = 64,
    parameter int DATA_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lac_pkg::cmd_t                 cmd,
    input  logic [1:0]                    mode,
    input  logic [KEY_BITS-1:0]           key,
    input  logic [DATA_BITS-1:0]          data_in,
    output logic                          hit,
    output logic [DATA_BITS-1:0]          data_out,
    output logic                          evicted,
    output logic [KEY_BITS-1:0]           evicted_key,
    output logic [$clog2(ENTRIES+1)-1:0]  occupancy,
    output logic [lac_pkg::CNT_BITS-1:0]  hit_count,
    output logic [lac_pkg::CNT_BITS-1:0]  miss_count,
    output logic [lac_pkg::CNT_BITS-1:0]  eviction_count
);
    import lac_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int OCC_W = $clog2(ENTRIES+1);
    localparam logic [OCC_W-1:0] FULL_CNT = OCC_W'(ENTRIES);
    localparam logic [CNT_BITS-1:0] SAT = '1;

    mode_t                mode_reg;
    logic [KEY_BITS-1:0]  key_in_reg;
    logic [DATA_BITS-1:0] din_reg;

    logic [ENTRIES-1:0]   valid_reg;
    logic [ENTRIES-1:0]   valid_next;
    logic [KEY_BITS-1:0]  key_reg [ENTRIES];
    logic [IDX_W-1:0]     rank_reg [ENTRIES];
    logic [IDX_W-1:0]     rank_next [ENTRIES];
    logic [OCC_W-1:0]     count_reg;
    logic [OCC_W-1:0]     count_next;
    logic [CNT_BITS-1:0]  hits_reg, hits_next;
    logic [CNT_BITS-1:0]  misses_reg, misses_next;
    logic [CNT_BITS-1:0]  evs_reg, evs_next;

    logic [DATA_BITS-1:0] data_mem [ENTRIES];
    logic [KEY_BITS-1:0]  key_mem [ENTRIES];

    // lookup results
    logic [ENTRIES-1:0]   match;
    logic [ENTRIES-1:0]   lru_match;
    logic [IDX_W-1:0]     hit_idx_c, lru_idx_c, free_idx_c, hit_rank_c;
    logic                 hit_reg;
    logic [IDX_W-1:0]     hit_idx_reg, lru_idx_reg, free_idx_reg, hit_rank_reg;
    logic                 full_reg;
    logic [DATA_BITS-1:0] data_rd_reg;
    logic [KEY_BITS-1:0]  evk_rd_reg;
    logic [IDX_W-1:0]     lru_rank;

    // commit decisions
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic                 touch_en;
    logic [IDX_W-1:0]     touch_idx;
    logic [IDX_W-1:0]     touch_rank;
    logic                 drop_en;
    logic                 ev_c;
    logic [DATA_BITS-1:0] dout_c;

    logic                 hit_out_reg;
    logic [DATA_BITS-1:0] dout_reg;
    logic                 ev_reg;
    logic [KEY_BITS-1:0]  evk_reg;
    logic [OCC_W-1:0]     occ_reg;
    logic [CNT_BITS-1:0]  hc_reg, mc_reg, ec_reg;

    assign lru_rank = IDX_W'(count_reg - OCC_W'(1));

    always_comb
    begin
        hit_idx_c  = '0;
        lru_idx_c  = '0;
        hit_rank_c = '0;
        free_idx_c = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]     = valid_reg[i] && (key_reg[i] == key_in_reg);
            lru_match[i] = valid_reg[i] && (rank_reg[i] == lru_rank);
            if (match[i])
            begin
                hit_idx_c  = hit_idx_c | IDX_W'(i);
                hit_rank_c = hit_rank_c | rank_reg[i];
            end
            if (lru_match[i])
            begin
                lru_idx_c = lru_idx_c | IDX_W'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx_c = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode_t'(mode);
            key_in_reg <= key;
            din_reg    <= data_in;
        end
        if (cmd.look)
        begin
            hit_reg      <= (|match) && (mode_reg != MODE_CLEAR);
            hit_idx_reg  <= hit_idx_c;
            hit_rank_reg <= hit_rank_c;
            lru_idx_reg  <= lru_idx_c;
            free_idx_reg <= free_idx_c;
            full_reg     <= (count_reg == FULL_CNT);
        end
        if (cmd.read)
        begin
            data_rd_reg <= data_mem[hit_idx_reg];
            evk_rd_reg  <= key_mem[lru_idx_reg];
        end
        if (cmd.commit && wr_en)
        begin
            key_mem[wr_idx]  <= key_in_reg;
            key_reg[wr_idx]  <= key_in_reg;
        end
        if (cmd.commit && (wr_en || (mode_reg == MODE_PUT && hit_reg && din_reg != '0)))
        begin
            data_mem[wr_en ? wr_idx : hit_idx_reg] <= din_reg;
        end
        if (cmd.commit)
        begin
            hit_out_reg <= hit_reg;
            dout_reg    <= dout_c;
            ev_reg      <= ev_c;
            evk_reg     <= ev_c ? evk_rd_reg : '0;
            occ_reg     <= count_next;
            hc_reg      <= hits_next;
            mc_reg      <= misses_next;
            ec_reg      <= evs_next;
        end
    end

    always_comb
    begin
        wr_en       = 1'b0;
        wr_idx      = free_idx_reg;
        touch_en    = 1'b0;
        touch_idx   = hit_idx_reg;
        touch_rank  = hit_rank_reg;
        drop_en     = 1'b0;
        ev_c        = 1'b0;
        dout_c      = '0;
        count_next  = count_reg;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        evs_next    = evs_reg;
        case (mode_reg)
            MODE_GET:
            begin
                if (hit_reg)
                begin
                    touch_en  = 1'b1;
                    dout_c    = data_rd_reg;
                    hits_next = (hits_reg == SAT) ? hits_reg : hits_reg + 1'b1;
                end
                else
                begin
                    misses_next = (misses_reg == SAT) ? misses_reg : misses_reg + 1'b1;
                end
            end
            MODE_PUT:
            begin
                if (din_reg != '0)
                begin
                    if (hit_reg)
                    begin
                        touch_en = 1'b1;
                    end
                    else if (!full_reg)
                    begin
                        wr_en      = 1'b1;
                        touch_en   = 1'b1;
                        touch_idx  = free_idx_reg;
                        touch_rank = IDX_W'(count_reg);
                        count_next = count_reg + OCC_W'(1);
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = lru_idx_reg;
                        touch_en   = 1'b1;
                        touch_idx  = lru_idx_reg;
                        touch_rank = lru_rank;
                        ev_c       = 1'b1;
                        evs_next   = (evs_reg == SAT) ? evs_reg : evs_reg + 1'b1;
                    end
                end
            end
            MODE_INVAL:
            begin
                if (hit_reg)
                begin
                    drop_en    = 1'b1;
                    count_next = count_reg - OCC_W'(1);
                end
            end
            MODE_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (touch_en && valid_reg[i] && rank_reg[i] < touch_rank)
            begin
                rank_next[i] = rank_reg[i] + IDX_W'(1);
            end
            if (drop_en && valid_reg[i] && rank_reg[i] > hit_rank_reg)
            begin
                rank_next[i] = rank_reg[i] - IDX_W'(1);
            end
        end
        if (touch_en)
        begin
            rank_next[touch_idx]  = '0;
            valid_next[touch_idx] = 1'b1;
        end
        if (drop_en)
        begin
            valid_next[hit_idx_reg] = 1'b0;
        end
        if (mode_reg == MODE_CLEAR)
        begin
            valid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            count_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            evs_reg    <= '0;
        end
        else if (cmd.commit)
        begin
            valid_reg  <= valid_next;
            count_reg  <= count_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            evs_reg    <= evs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    assign hit            = hit_out_reg;
    assign data_out       = dout_reg;
    assign evicted        = ev_reg;
    assign evicted_key    = evk_reg;
    assign occupancy      = occ_reg;
    assign hit_count      = hc_reg;
    assign miss_count     = mc_reg;
    assign eviction_count = ec_reg;

endmodule

[sv/lru_associative_cache_core.sv]
`timescale 1ns / 1ps
// top level of the fully associative lru cache
// depends on lac_pkg, lac_ctrl and lac_datapath

// Fully associative cache of key/data pairs kept in least recently used order.
// Each transaction goes through these steps from acceptance to result: accept it,
// compare all stored keys in parallel, do the registered reads of the data and
// key memories, and update the recency ranks, the valid bits and the counters.
// One transaction is in flight at a time; the result register lets the next
// transaction be accepted while a result waits.

module lru_associative_cache_core #(
    parameter int ENTRIES   = 64,
    parameter int KEY_BITS  = 64,
    parameter int DATA_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic [KEY_BITS-1:0]           key,
    input  logic [DATA_BITS-1:0]          data_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic [DATA_BITS-1:0]          data_out,
    output logic                          evicted,
    output logic [KEY_BITS-1:0]           evicted_key,
    output logic [$clog2(ENTRIES+1)-1:0]  occupancy,
    output logic [lac_pkg::CNT_BITS-1:0]  hit_count,
    output logic [lac_pkg::CNT_BITS-1:0]  miss_count,
    output logic [lac_pkg::CNT_BITS-1:0]  eviction_count
);
    import lac_pkg::*;

    cmd_t cmd;

    lac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    lac_datapath #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .mode           (mode),
        .key            (key),
        .data_in        (data_in),
        .hit            (hit),
        .data_out       (data_out),
        .evicted        (evicted),
        .evicted_key    (evicted_key),
        .occupancy      (occupancy),
        .hit_count      (hit_count),
        .miss_count     (miss_count),
        .eviction_count (eviction_count)
    );

`ifndef SYNTH
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction accepted while busy");
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy <= ($clog2(ENTRIES+1))'(ENTRIES)))
        else $error("occupancy above capacity");
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted) |-> (occupancy == ($clog2(ENTRIES+1))'(ENTRIES)))
        else $error("eviction without a full cache");
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted) |-> !hit)
        else $error("eviction on a hit");
`endif

endmodule
